[rtl/core/fwdp_pkg.sv]
// Shared types and constants for the fixed-width decimal digit placer.
package fwdp_pkg;

    localparam int NUM_BITS           = 32;
    localparam int COUNT_WIDTH        = $clog2(NUM_BITS);
    localparam int CELL_WIDTH         = 8;
    localparam int DEFAULT_MAX_DIGITS = 10;

    localparam logic [7:0] COLUMN_LIMIT_RESET = 8'd120;
    localparam logic [1:0] ROW_LIMIT_RESET    = 2'd3;

    typedef enum logic [1:0] {
        REG_COLUMN_LIMIT = 2'd0,
        REG_ROW_LIMIT    = 2'd1
    } reg_index_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT,
        S_ERR
    } state_t;

endpackage

[rtl/core/fixed_width_decimal_digit_placer.sv]
// Top level: range check, iterative binary to BCD conversion and digit emission.
// An accepted word is range checked at once; a rejected word yields one error word
// on the next cycle. A good word is shifted through the shared shift-and-add-3 unit
// (one number bit per cycle), then emits one word per digit, most significant first,
// one per cycle while the output is taken. The input is not ready until the last
// output word of a word is taken.
module fixed_width_decimal_digit_placer
    import fwdp_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // start_column[7:0], text_row[15:8], number[47:16], digit_count[55:48]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // digit[3:0], column[11:4], page[14:12], zero pad[15]
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // range_error[0]
    output logic        m_axis_tuser
);

    localparam int PW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int BW = 4 * MAX_DIGITS;

    state_t state_reg, state_next;

    logic [7:0]             column_limit_reg;
    logic [1:0]             row_limit_reg;
    logic [NUM_BITS-1:0]    number_reg;
    logic [BW-1:0]          bcd_reg;
    logic [BW-1:0]          bcd_step;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [PW-1:0]          pos_reg;
    logic [7:0]             column_reg;
    logic [2:0]             page_reg;

    logic [7:0]  in_column;
    logic [7:0]  in_row;
    logic [7:0]  in_count;
    logic [11:0] right_edge;
    logic        bad;
    logic        in_fire;
    logic        out_fire;

    assign in_column = s_axis_tdata[7:0];
    assign in_row    = s_axis_tdata[15:8];
    assign in_count  = s_axis_tdata[55:48];

    assign right_edge = {4'd0, in_column} + {1'b0, in_count, 3'd0};
    assign bad = (in_count == 8'd0) || (in_count > 8'(MAX_DIGITS))
              || (in_row > {6'd0, row_limit_reg})
              || (right_edge > {4'd0, column_limit_reg});

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    fwdp_dabble_step #(
        .DIGITS(MAX_DIGITS)
    ) u_step (
        .bcd      (bcd_reg),
        .bit_in   (number_reg[NUM_BITS-1]),
        .bcd_next (bcd_step)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_limit_reg <= COLUMN_LIMIT_RESET;
            row_limit_reg    <= ROW_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COLUMN_LIMIT: column_limit_reg <= cfg_data;
                REG_ROW_LIMIT:    row_limit_reg    <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = bad ? S_ERR : S_CONV;
                end
            end
            S_CONV:
            begin
                if (count_reg == COUNT_WIDTH'(NUM_BITS - 1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_fire && pos_reg == '0)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (out_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        m_axis_tdata  = '0;
        m_axis_tlast  = 1'b0;
        m_axis_tuser  = 1'b0;
        unique case (state_reg)
            S_IDLE: s_axis_tready = 1'b1;
            S_CONV: ;
            S_EMIT:
            begin
                m_axis_tvalid = 1'b1;
                m_axis_tdata  = {1'b0, page_reg, column_reg, bcd_reg[4*pos_reg +: 4]};
                m_axis_tlast  = (pos_reg == '0);
            end
            S_ERR:
            begin
                m_axis_tvalid = 1'b1;
                m_axis_tlast  = 1'b1;
                m_axis_tuser  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                count_reg <= '0;
            end
            else if (state_reg == S_CONV)
            begin
                count_reg <= count_reg + COUNT_WIDTH'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            number_reg <= s_axis_tdata[47:16];
            bcd_reg    <= '0;
            pos_reg    <= PW'(in_count - 8'd1);
            column_reg <= in_column;
            page_reg   <= {in_row[1:0], 1'b0};
        end
        else if (state_reg == S_CONV)
        begin
            number_reg <= {number_reg[NUM_BITS-2:0], 1'b0};
            bcd_reg    <= bcd_step;
        end
        else if (state_reg == S_EMIT && out_fire)
        begin
            pos_reg    <= pos_reg - PW'(1);
            column_reg <= column_reg + 8'(CELL_WIDTH);
        end
    end

endmodule

[rtl/core/fwdp_dabble_step.sv]
// One shift-and-add-3 step of the binary to BCD conversion.
module fwdp_dabble_step
    import fwdp_pkg::*;
#(
    parameter int DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  logic [4*DIGITS-1:0] bcd,
    input  logic                bit_in,
    output logic [4*DIGITS-1:0] bcd_next
);

    logic [4*DIGITS-1:0] adjusted;

    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd[4*d +: 4] >= 4'd5)
            begin
                adjusted[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
            end
            else
            begin
                adjusted[4*d +: 4] = bcd[4*d +: 4];
            end
        end
        // carry out of the top digit is dropped: keeps the value mod 10^DIGITS
        bcd_next = {adjusted[4*DIGITS-2:0], bit_in};
    end

endmodule

[dv/tb_top.sv]
// Testbench for the fixed-width decimal digit placer: directed and random words checked by a predictor.
module tb_top;
    import fwdp_pkg::*;

    localparam int         CLK_HALF     = 10;
    localparam int         RESET_CYCLES = 12;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         RANDOM_WORDS = 260;
    localparam int         RANDOM_PHASES = 6;
    localparam int         MAX_PRINTS   = 50;
    localparam int         TAIL_CYCLES  = 60;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         DECIMAL_BASE = 10;
    localparam int         PAGES_PER_ROW = 2;
    localparam logic [1:0] REG_SPARE_2  = 2'd2;
    localparam logic [1:0] REG_SPARE_3  = 2'd3;

    typedef struct packed {
        logic [7:0]  digit_count;
        logic [31:0] number;
        logic [7:0]  text_row;
        logic [7:0]  start_column;
    } placement_t;

    typedef struct {
        logic [3:0] digit;
        logic [7:0] column;
        logic [2:0] page;
        logic       last;
        logic       range_error;
    } digit_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // start_column[7:0], text_row[15:8], number[47:16], digit_count[55:48]
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // digit[3:0], column[11:4], page[14:12], zero pad[15]
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    // range_error[0]
    logic        m_axis_tuser;

    digit_word_t pending_digits[$];
    logic [7:0]  col_lim;
    logic [1:0]  row_lim;
    bit          steady;
    int          hold_request;
    int          err_count;
    int          cycle_count;

    fixed_width_decimal_digit_placer uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // expected digit words for one accepted placement under the current limits
    function automatic void place_digits(input placement_t w);
        digit_word_t r;
        logic [3:0]  digs [DEFAULT_MAX_DIGITS];
        logic [31:0] rest;
        int          cnt;
        bit          bad;
        cnt = w.digit_count;
        bad = (cnt == 0) || (cnt > DEFAULT_MAX_DIGITS) || (w.text_row > row_lim)
              || (int'(w.start_column) + CELL_WIDTH * cnt > int'(col_lim));
        if (bad)
        begin
            r = '{digit: 4'd0, column: 8'd0, page: 3'd0, last: 1'b1, range_error: 1'b1};
            pending_digits.push_back(r);
            return;
        end
        rest = w.number;
        for (int i = cnt - 1; i >= 0; i--)
        begin
            digs[i] = 4'(rest % DECIMAL_BASE);
            rest    = rest / DECIMAL_BASE;
        end
        for (int i = 0; i < cnt; i++)
        begin
            r.digit       = digs[i];
            r.column      = w.start_column + 8'(CELL_WIDTH * i);
            r.page        = 3'(w.text_row * PAGES_PER_ROW);
            r.last        = (i == cnt - 1);
            r.range_error = 1'b0;
            pending_digits.push_back(r);
        end
    endfunction

    always @(posedge clk)
    begin : check_output
        digit_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_digits.size() == 0)
                report_mismatch("output word with nothing expected");
            else
            begin
                want = pending_digits.pop_front();
                if (m_axis_tdata[3:0] !== want.digit)
                    report_mismatch($sformatf("digit %0d, want %0d",
                                              m_axis_tdata[3:0], want.digit));
                if (m_axis_tdata[11:4] !== want.column)
                    report_mismatch($sformatf("column %0d, want %0d",
                                              m_axis_tdata[11:4], want.column));
                if (m_axis_tdata[14:12] !== want.page)
                    report_mismatch($sformatf("page %0d, want %0d",
                                              m_axis_tdata[14:12], want.page));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last %b, want %b", m_axis_tlast, want.last));
                if (m_axis_tuser !== want.range_error)
                    report_mismatch($sformatf("range_error %b, want %b",
                                              m_axis_tuser, want.range_error));
            end
        end
    end

    // output side: random stalls, steady stretches and one long hold-off
    initial
    begin : drain_side
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= steady || ($urandom_range(99) >= 30);
        end
    end

    // valid stays high from one word to the next unless a gap is drawn
    task automatic send_word(input logic [7:0] x, input logic [7:0] y,
                             input logic [31:0] n, input logic [7:0] cnt);
        placement_t w;
        w = '{digit_count: cnt, number: n, text_row: y, start_column: x};
        while (!steady && $urandom_range(99) < 30)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do
            @(posedge clk);
        while (!s_axis_tready);
        place_digits(w);
    endtask

    task automatic finish_words();
        s_axis_tvalid <= 1'b0;
        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // row_data may carry junk in its upper bits to exercise masking
    task automatic set_limits(input logic [7:0] col, input logic [7:0] row_data);
        cfg_we    <= 1'b1;
        cfg_index <= REG_COLUMN_LIMIT;
        cfg_data  <= col;
        @(posedge clk);
        cfg_index <= REG_ROW_LIMIT;
        cfg_data  <= row_data;
        @(posedge clk);
        cfg_index <= $urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3;
        cfg_data  <= 8'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        col_lim = col;
        row_lim = row_data[1:0];
    endtask

    task automatic test_default_limits();
        send_word(8'd0,   8'd0,   32'd0,          8'd1);
        send_word(8'd40,  8'd3,   32'hFFFF_FFFF,  8'd10);
        send_word(8'd41,  8'd3,   32'hFFFF_FFFF,  8'd10);   // one column past the edge
        send_word(8'd0,   8'd0,   32'd5,          8'd0);
        send_word(8'd0,   8'd0,   32'd5,          8'd11);
        send_word(8'd0,   8'd0,   32'd5,          8'd255);
        send_word(8'd0,   8'd4,   32'd5,          8'd1);
        send_word(8'd255, 8'd255, 32'd5,          8'd1);
        send_word(8'd7,   8'd1,   32'd1234567890, 8'd5);    // high digits dropped
        send_word(8'd16,  8'd2,   32'd9,          8'd3);    // zero padded
        finish_words();
    endtask

    task automatic test_limit_extremes();
        set_limits(8'd255, 8'hFF);
        send_word(8'd175, 8'd3, 32'd4000000000, 8'd10);
        send_word(8'd176, 8'd3, 32'd4000000000, 8'd10);
        send_word(8'd247, 8'd2, 32'd7,          8'd1);
        send_word(8'd248, 8'd2, 32'd7,          8'd1);
        finish_words();
        set_limits(8'd0, 8'h00);
        send_word(8'd0, 8'd0, 32'd1, 8'd1);
        finish_words();
        set_limits(8'd8, 8'hFC);
        send_word(8'd0, 8'd0, 32'd8, 8'd1);
        send_word(8'd0, 8'd1, 32'd8, 8'd1);
        finish_words();
    endtask

    task automatic test_backpressure();
        set_limits(8'd255, 8'd3);
        hold_request = HOLD_CYCLES;
        for (int k = 0; k < 6; k++)
            send_word(8'(8 * k), 8'(k % 4), $urandom, 8'd10);
        finish_words();
    endtask

    task automatic test_random_words();
        logic [7:0]  cols [RANDOM_PHASES] = '{8'd120, 8'd255, 8'd255, 8'd200, 8'd96, 8'd0};
        logic [1:0]  rows [RANDOM_PHASES] = '{2'd3, 2'd3, 2'd0, 2'd2, 2'd1, 2'd0};
        int          max_cnt;
        int          cnt;
        int          x;
        int          y;
        logic [31:0] n;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_limits(cols[p], {6'($urandom), rows[p]});
            steady = (p == 2);
            for (int k = 0; k < RANDOM_WORDS / RANDOM_PHASES; k++)
            begin
                max_cnt = col_lim / CELL_WIDTH;
                if (max_cnt > DEFAULT_MAX_DIGITS)
                    max_cnt = DEFAULT_MAX_DIGITS;
                if (max_cnt > 0 && $urandom_range(99) < 80)
                begin
                    cnt = $urandom_range(1, max_cnt);
                    x   = $urandom_range(0, col_lim - CELL_WIDTH * cnt);
                    y   = $urandom_range(0, row_lim);
                end
                else
                begin
                    cnt = $urandom_range(1) ? $urandom_range(0, 12) : $urandom_range(0, 255);
                    x   = $urandom_range(0, 255);
                    y   = $urandom_range(1) ? $urandom_range(0, 7) : $urandom_range(0, 255);
                end
                n = $urandom >> $urandom_range(0, 31);
                send_word(8'(x), 8'(y), n, 8'(cnt));
            end
            finish_words();
            steady = 1'b0;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_COLUMN_LIMIT;
        cfg_data      = 8'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        col_lim       = COLUMN_LIMIT_RESET;
        row_lim       = ROW_LIMIT_RESET;
        steady        = 1'b0;
        hold_request  = 0;
        err_count     = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_limits();
        test_limit_extremes();
        test_backpressure();
        test_random_words();
        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/fwdp_pkg.sv
rtl/core/fwdp_dabble_step.sv
rtl/core/fixed_width_decimal_digit_placer.sv
dv/tb_top.sv
